FILE: design/mbr_pkg.sv
package mbr_pkg;

  localparam int NUM_BALLS        = 4;
  localparam int PIXEL_COLS       = 16;
  localparam int PIXEL_ROWS       = 16;
  localparam int GAMMA_HUNDREDTHS = 220;

  localparam int BALL_W   = (NUM_BALLS > 1) ? $clog2(NUM_BALLS) : 1;
  localparam int PIX_N    = PIXEL_COLS * PIXEL_ROWS;
  localparam int PIX_W    = $clog2(PIX_N);
  localparam int IN_DW    = 80;
  localparam int OUT_DW   = 24;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 20;

  // Operation codes carried in in_tuser
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_RENDER  = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_RAD2      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CAP       = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ASPECT    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_X_LIMIT   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_Y_LIMIT   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RR, S_SY, S_SYW, S_DX, S_DY, S_DSUM, S_RD, S_DIVL, S_DIV,
    S_ACC, S_NEXT, S_IDX, S_GAM, S_ADV, S_OUT
  } mbr_state_t;

  typedef logic [7:0] gamma_tab_t [256];

  // log2 of v in Q.16 by bit-serial squaring of the mantissa
  function automatic longint lg_q16(int v);
    int              e;
    longint unsigned m;
    longint          frac;
    e    = 0;
    frac = 0;
    while (e < 7 && (v >> (e + 1)) != 0) e++;
    m = longint'(v) << (30 - e);
    for (int k = 0; k < 16; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << 16) | frac;
  endfunction

  function automatic gamma_tab_t build_gamma();
    gamma_tab_t t;
    longint     lg [256];
    longint     rhs;
    int         best;
    bit         stop;
    lg[0] = 0;
    for (int i = 1; i < 256; i++) lg[i] = lg_q16(i);
    t[0] = 8'd0;
    for (int i = 1; i < 256; i++) begin
      best = 0;
      stop = 1'b0;
      rhs  = 100 * (lg[i] - lg[255]);
      for (int b = 1; b < 256; b++) begin
        if (!stop) begin
          if (GAMMA_HUNDREDTHS * (lg[b] - lg[255]) <= rhs) best = b;
          else stop = 1'b1;
        end
      end
      t[i] = 8'(best);
    end
    return t;
  endfunction

  localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage

FILE: design/metaball_field_renderer_core.sv
// Channel | Ports                      | Contents (lowest bit first)
// in      | in_tvalid/tready/tdata/tuser | tuser: func; tdata: ball_index, load_pos_x,
//         |                            |   load_pos_y, load_vel_x, load_vel_y, pixel_col, pixel_row
// out     | out_tvalid/tready/tdata    | tdata: out_col, out_row, brightness, changed
// cfg     | cfg_we/index/wdata         | influence r2, cap level, row scale, x limit, y limit
//
// In a render each ball in reach passes three multiplies on the shared multiplier and nine
// steps of the shared restoring divider (a ball out of reach skips the divider), and the
// divider also forms the normalized index in 8 steps, skipped when the cap is zero.
// One item is worked at a time; in_tready is high only while idle.
// A result waits in the output register and the next item is taken meanwhile.
// Reset (rst_n, synchronous) clears balls and pixel valid bits and sets registers to defaults.
module metaball_field_renderer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mbr_pkg::IN_DW-1:0]   in_tdata,  // ball_index, pos_x, pos_y, vel_x, vel_y, col, row
  input  logic [1:0]                  in_tuser,  // func
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mbr_pkg::OUT_DW-1:0]  out_tdata, // out_col, out_row, brightness, changed
  input  logic                        cfg_we,
  input  logic [mbr_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [mbr_pkg::CFG_DW-1:0]  cfg_wdata
);
  import mbr_pkg::*;

  mbr_state_t state_r, state_nxt;

  logic [19:0] rsq_r;
  logic [15:0] cap_r, asp_r;
  logic [5:0]  xlim_r, ylim_r;

  logic [15:0] bx_r [NUM_BALLS];
  logic [15:0] by_r [NUM_BALLS];
  logic [15:0] bdx_r [NUM_BALLS];
  logic [15:0] bdy_r [NUM_BALLS];

  logic [3:0]  col_r, row_r;
  logic [BALL_W-1:0] k_r, k_nxt;
  logic        ax_r, ax_nxt;
  logic signed [41:0] prod_r;
  logic signed [20:0] mul_a, mul_b;
  logic [39:0] rr_r, rr_nxt;
  logic [17:0] sy_r, sy_nxt;
  logic [41:0] acc_r, acc_nxt;
  logic [29:0] d_r, d_nxt;
  logic [47:0] rem_r, rem_nxt, div_r, div_nxt;
  logic [8:0]  q_r, q_nxt;
  logic [3:0]  qc_r, qc_nxt;
  logic        idiv_r, idiv_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [OUT_DW-1:0] res_r, res_nxt;
  logic        out_v_r;
  logic [OUT_DW-1:0] out_d_r;
  logic [PIX_N-1:0] pv_r;

  logic        in_acc, out_load, last_ball, div_ge;
  logic [48:0] trial;
  logic        in_range;
  logic [PIX_W-1:0] pix_addr;
  logic [7:0]  ram_rd, br, prev;
  logic        chg, ram_we;

  logic signed [17:0] p_s, np_s;
  logic [15:0] pos, vel, nvel, lim;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_load   = (state_r == S_OUT) && (!out_v_r || out_tready);
  assign last_ball  = (k_r == BALL_W'(NUM_BALLS - 1));

  assign in_range = ({2'b00, col_r} < 6'(PIXEL_COLS)) && ({2'b00, row_r} < 6'(PIXEL_ROWS));
  assign pix_addr = PIX_W'(int'(row_r) * PIXEL_COLS + int'(col_r));

  // Shared divider step: one subtract per cycle
  assign trial  = {1'b0, rem_r} - {1'b0, div_r};
  assign div_ge = !trial[48];

  mbr_ram #(.WIDTH(8), .DEPTH(PIX_N)) u_last (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pix_addr),
    .wdata(br),
    .re   (state_r == S_RR),
    .raddr(pix_addr),
    .rdata(ram_rd)
  );

  // Tone map and compare against the stored brightness
  assign br     = GAMMA_TAB[q_r[7:0]];
  assign prev   = pv_r[pix_addr] ? ram_rd : 8'd0;
  assign chg    = in_range && (prev != br);
  assign ram_we = (state_r == S_GAM) && chg;

  // Advance one axis of one ball
  always_comb begin
    pos  = ax_r ? by_r[k_r] : bx_r[k_r];
    vel  = ax_r ? bdy_r[k_r] : bdx_r[k_r];
    lim  = {ax_r ? ylim_r : xlim_r, 10'd0};
    p_s  = $signed({2'b00, pos}) + 18'($signed(vel));
    np_s = p_s;
    nvel = vel;
    if (p_s < 0) begin
      np_s = 18'sd0;
      nvel = (nvel == 16'h8000) ? 16'h7fff : 16'(-nvel);
    end
    if (np_s >= $signed({2'b00, lim})) begin
      np_s = $signed({2'b00, lim}) - 18'sd1024;
      nvel = (nvel == 16'h8000) ? 16'h7fff : 16'(-nvel);
    end
    if (np_s < 0) np_s = 18'sd0;
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RR: begin
        mul_a = $signed({1'b0, rsq_r});
        mul_b = $signed({1'b0, rsq_r});
      end
      S_SY: begin
        mul_a = $signed({17'd0, row_r});
        mul_b = $signed({5'd0, asp_r});
      end
      S_DX: begin
        mul_a = $signed({5'd0, bx_r[k_r]}) - $signed({7'd0, col_r, 10'd0});
        mul_b = mul_a;
      end
      S_DY: begin
        mul_a = $signed({5'd0, by_r[k_r]}) - $signed({3'd0, sy_r});
        mul_b = mul_a;
      end
      S_RD: begin
        mul_a = $signed({1'b0, rsq_r - d_r[19:0]});
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) begin
        unique case (in_tuser)
          FUNC_RENDER:  state_nxt = S_RR;
          FUNC_ADVANCE: state_nxt = S_ADV;
          default:      state_nxt = S_OUT;
        endcase
      end
      S_RR:   state_nxt = S_SY;
      S_SY:   state_nxt = S_SYW;
      S_SYW:  state_nxt = S_DX;
      S_DX:   state_nxt = S_DY;
      S_DY:   state_nxt = S_DSUM;
      S_DSUM: state_nxt = S_RD;
      S_RD:   state_nxt = (rsq_r == 20'd0 || d_r > {10'd0, rsq_r}) ? S_NEXT : S_DIVL;
      S_DIVL: state_nxt = S_DIV;
      S_DIV:  if (qc_r == 4'd0) state_nxt = idiv_r ? S_GAM : S_ACC;
      S_ACC:  state_nxt = S_NEXT;
      S_NEXT: state_nxt = last_ball ? S_IDX : S_DX;
      S_IDX:  state_nxt = (cap_r == 16'd0) ? S_GAM : S_DIV;
      S_GAM:  state_nxt = S_OUT;
      S_ADV:  if (ax_r && last_ball) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    k_nxt    = k_r;
    ax_nxt   = ax_r;
    rr_nxt   = rr_r;
    sy_nxt   = sy_r;
    acc_nxt  = acc_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    qc_nxt   = qc_r;
    idiv_nxt = idiv_r;
    sum_nxt  = sum_r;
    res_nxt  = res_r;
    unique case (state_r)
      S_IDLE: begin
        k_nxt   = '0;
        ax_nxt  = 1'b0;
        sum_nxt = '0;
        res_nxt = '0;
        idiv_nxt = 1'b0;
      end
      S_SY:   rr_nxt = prod_r[39:0];
      S_SYW:  sy_nxt = prod_r[19:2];
      S_DY:   acc_nxt = prod_r;
      S_DSUM: d_nxt = 30'((acc_r + prod_r) >> 12);
      S_DIVL: begin
        rem_nxt = {prod_r[39:0], 8'd0};
        div_nxt = {rr_r, 8'd0};
        q_nxt   = '0;
        qc_nxt  = 4'd8;
      end
      S_DIV: begin
        if (div_ge) rem_nxt = trial[47:0];
        q_nxt   = {q_r[7:0], div_ge};
        div_nxt = div_r >> 1;
        qc_nxt  = qc_r - 4'd1;
      end
      S_ACC:  sum_nxt = sum_r + {7'd0, q_r};
      S_NEXT: k_nxt = k_r + BALL_W'(1);
      S_IDX: begin
        // Cap the sum, then divide sum*255 by the cap
        idiv_nxt = 1'b1;
        q_nxt    = '0;
        qc_nxt   = 4'd7;
        div_nxt  = {25'd0, cap_r, 7'd0};
        if (sum_r > cap_r) rem_nxt = {24'd0, cap_r, 8'd0} - {32'd0, cap_r};
        else               rem_nxt = {24'd0, sum_r, 8'd0} - {32'd0, sum_r};
      end
      S_GAM:  res_nxt = {7'd0, chg, br, row_r, col_r};
      S_ADV: begin
        ax_nxt = !ax_r;
        if (ax_r) k_nxt = k_r + BALL_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
      rsq_r   <= 20'd4096;
      cap_r   <= 16'd256;
      asp_r   <= 16'd4096;
      xlim_r  <= 6'd16;
      ylim_r  <= 6'd16;
      pv_r    <= '0;
      for (int i = 0; i < NUM_BALLS; i++) begin
        bx_r[i]  <= '0;
        by_r[i]  <= '0;
        bdx_r[i] <= '0;
        bdy_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RAD2:      rsq_r  <= cfg_wdata;
          REG_CAP:       cap_r  <= cfg_wdata[15:0];
          REG_ASPECT:    asp_r  <= cfg_wdata[15:0];
          REG_X_LIMIT:   xlim_r <= cfg_wdata[5:0];
          REG_Y_LIMIT:   ylim_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      // Load one ball
      if (in_acc && in_tuser == FUNC_LOAD && {1'b0, in_tdata[3:0]} < 5'(NUM_BALLS)) begin
        bx_r[in_tdata[BALL_W-1:0]]  <= in_tdata[19:4];
        by_r[in_tdata[BALL_W-1:0]]  <= in_tdata[35:20];
        bdx_r[in_tdata[BALL_W-1:0]] <= in_tdata[51:36];
        bdy_r[in_tdata[BALL_W-1:0]] <= in_tdata[67:52];
      end
      // Move one axis
      if (state_r == S_ADV) begin
        if (ax_r) begin
          by_r[k_r]  <= np_s[15:0];
          bdy_r[k_r] <= nvel;
        end else begin
          bx_r[k_r]  <= np_s[15:0];
          bdx_r[k_r] <= nvel;
        end
      end
      if (ram_we) pv_r[pix_addr] <= 1'b1;
      // Output register
      if (out_load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    k_r    <= k_nxt;
    ax_r   <= ax_nxt;
    rr_r   <= rr_nxt;
    sy_r   <= sy_nxt;
    acc_r  <= acc_nxt;
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    qc_r   <= qc_nxt;
    idiv_r <= idiv_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    if (in_acc) begin
      col_r <= in_tdata[71:68];
      row_r <= in_tdata[75:72];
    end
    if (out_load) out_d_r <= res_r;
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE) else $error("accepted item left block idle");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && qc_r == 4'd0) |=> state_r != S_DIV)
    else $error("divider overran its step count");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDX |-> sum_r <= 16'(NUM_BALLS * 256))
    else $error("field sum beyond ball count");

  a_chg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> in_range) else $error("stored brightness for pixel off the matrix");

endmodule

FILE: design/mbr_ram.sv
module mbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
